// ===== rtl/netstring_metadata_deframer_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the netstring metadata deframer
// Clocked on clock; NMD_ASSERT is disabled in reset, NMD_ASSERT_RST is not.
// ----------------------------------------------------------------------------
`ifndef NETSTRING_METADATA_DEFRAMER_ASSERT_SVH
`define NETSTRING_METADATA_DEFRAMER_ASSERT_SVH

`ifndef SYNTH

`define NMD_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

`define NMD_ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) (prop)) else $error(msg);

`else

`define NMD_ASSERT(lbl, prop, msg)

`define NMD_ASSERT_RST(lbl, prop, msg)

`endif

`endif

// ===== rtl/nmd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmd_pkg
// Types and codes shared by the netstring metadata deframer modules.
// ----------------------------------------------------------------------------
package nmd_pkg;

   localparam int MaxDigits  = 9;
   localparam int CountBits  = 32;
   localparam logic [31:0] CountMask = 32'((64'd1 << CountBits) - 64'd1);

   localparam int RspDepth   = 4;
   localparam int RspPtrBits = $clog2(RspDepth);

   localparam logic [7:0] CharColon = 8'h3A;
   localparam logic [7:0] CharComma = 8'h2C;
   localparam logic [7:0] CharZero  = 8'h30;
   localparam logic [7:0] CharNine  = 8'h39;

   // result kinds
   localparam logic [1:0] KindByte   = 2'd0;
   localparam logic [1:0] KindEnd    = 2'd1;
   localparam logic [1:0] KindStatus = 2'd2;

   // frame status codes
   localparam logic [3:0] StOk       = 4'd0;
   localparam logic [3:0] StHdrShort = 4'd1;
   localparam logic [3:0] StTooShort = 4'd2;
   localparam logic [3:0] StNoColon  = 4'd3;
   localparam logic [3:0] StNoComma  = 4'd4;
   localparam logic [3:0] StLeadZero = 4'd5;
   localparam logic [3:0] StNoLength = 4'd6;
   localparam logic [3:0] StTooLong  = 4'd7;
   localparam logic [3:0] StMissing  = 4'd8;

   // parser phases
   localparam logic [2:0] PhHead    = 3'd0;
   localparam logic [2:0] PhFirst   = 3'd1;
   localparam logic [2:0] PhDigits  = 3'd2;
   localparam logic [2:0] PhPayload = 3'd3;
   localparam logic [2:0] PhComma   = 3'd4;
   localparam logic [2:0] PhIdle    = 3'd5;
   localparam logic [2:0] PhError   = 3'd6;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  out_byte;
      logic        is_value;
      logic [31:0] entry_index;
      logic [29:0] string_length;
      logic [3:0]  status;
      logic [31:0] entry_count;
      logic        last;
   } nmd_result_type;

   typedef struct packed {
      logic [1:0]     count;
      nmd_result_type first;
      nmd_result_type second;
   } nmd_push_type;

endpackage

// ===== rtl/nmd_rsp_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmd_rsp_fifo
// Result queue: up to two results in a cycle, one out a cycle while rsp_ready.
// ----------------------------------------------------------------------------
module nmd_rsp_fifo
   import nmd_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  nmd_push_type   push,
   output logic           space_ok,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output nmd_result_type rsp_data
);

   `include "netstring_metadata_deframer_assert.svh"

   nmd_result_type mem_ff [RspDepth];
   logic [RspPtrBits-1:0] wr_ptr_ff, wr_ptr_in;
   logic [RspPtrBits-1:0] rd_ptr_ff, rd_ptr_in;
   logic [RspPtrBits:0]   count_ff, count_in;
   logic                  pop;
   logic [RspPtrBits-1:0] wr_next;

   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = mem_ff[rd_ptr_ff];
   assign pop       = rsp_valid && rsp_ready;
   assign space_ok  = (count_ff <= (RspPtrBits + 1)'(RspDepth - 2));
   assign wr_next   = wr_ptr_ff + 1'b1;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + RspPtrBits'(push.count);
      rd_ptr_in = rd_ptr_ff + RspPtrBits'(pop);
      count_in  = count_ff + (RspPtrBits + 1)'(push.count) - (RspPtrBits + 1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_next] <= push.second;
      end
   end

   `NMD_ASSERT(a_fifo_bound, count_ff <= (RspPtrBits + 1)'(RspDepth), "result queue overflow")
   `NMD_ASSERT(a_fifo_pop,
      pop && (push.count == 2'd0) |=> count_ff == $past(count_ff) - 1'b1,
      "result queue pop lost")
   `NMD_ASSERT_RST(a_fifo_reset, reset |=> count_ff == '0, "result queue not empty after reset")

endmodule

// ===== rtl/nmd_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmd_parser
// Frame parser: header count, netstring digits, payload, comma and status.
// ----------------------------------------------------------------------------
module nmd_parser
   import nmd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         accept,
   input  logic [7:0]   data_byte,
   input  logic         frame_end,
   input  logic         swap_count,
   output nmd_push_type push
);

   `include "netstring_metadata_deframer_assert.svh"

   logic [2:0]  phase_ff, phase_in;
   logic [2:0]  header_bytes_ff, header_bytes_in;
   logic [31:0] count_value_ff, count_value_in;
   logic [31:0] entries_left_ff, entries_left_in;
   logic [31:0] pair_index_ff, pair_index_in;
   logic [3:0]  digit_count_ff, digit_count_in;
   logic [29:0] length_accum_ff, length_accum_in;
   logic [29:0] payload_left_ff, payload_left_in;
   logic        value_side_ff, value_side_in;
   logic [3:0]  pending_error_ff, pending_error_in;
   logic [31:0] bytes_required_ff, bytes_required_in;
   logic [31:0] bytes_since_ff, bytes_since_in;

   always_comb begin
      logic           digit;
      logic [29:0]    dval;
      logic [3:0]     st;
      nmd_result_type r0;
      nmd_result_type r1;
      logic           r0_valid;

      digit = data_byte inside {[CharZero:CharNine]};
      dval  = 30'(data_byte - CharZero);

      phase_in          = phase_ff;
      header_bytes_in   = header_bytes_ff;
      count_value_in    = count_value_ff;
      entries_left_in   = entries_left_ff;
      pair_index_in     = pair_index_ff;
      digit_count_in    = digit_count_ff;
      length_accum_in   = length_accum_ff;
      payload_left_in   = payload_left_ff;
      value_side_in     = value_side_ff;
      pending_error_in  = pending_error_ff;
      bytes_required_in = bytes_required_ff;
      bytes_since_in    = bytes_since_ff;

      r0       = '0;
      r1       = '0;
      r0_valid = 1'b0;
      st       = StOk;

      if (accept) begin
         if ((phase_ff != PhHead) && (phase_ff != PhIdle) && (bytes_since_ff != '1)) begin
            bytes_since_in = bytes_since_ff + 32'd1;
         end

         case (phase_ff)
            PhHead: begin
               if (swap_count) begin
                  count_value_in = {count_value_ff[23:0], data_byte};
               end else begin
                  count_value_in = count_value_ff
                                 | (32'(data_byte) << {header_bytes_ff[1:0], 3'b000});
               end
               header_bytes_in = header_bytes_ff + 3'd1;
               if (header_bytes_in >= 3'd4) begin
                  count_value_in  = count_value_in & CountMask;
                  entries_left_in = count_value_in;
                  bytes_since_in  = '0;
                  phase_in        = (count_value_in == '0) ? PhIdle : PhFirst;
               end
            end
            PhFirst: begin
               bytes_required_in = 32'd3;
               if (!digit) begin
                  pending_error_in = StNoLength;
                  phase_in         = PhError;
               end else begin
                  digit_count_in  = 4'd1;
                  length_accum_in = dval;
                  phase_in        = PhDigits;
               end
            end
            PhDigits: begin
               if (digit) begin
                  if ((digit_count_ff == 4'd1) && (length_accum_ff == '0)) begin
                     pending_error_in = StLeadZero;
                     phase_in         = PhError;
                  end else if (digit_count_ff >= 4'(MaxDigits)) begin
                     pending_error_in = StTooLong;
                     phase_in         = PhError;
                  end else begin
                     length_accum_in = (length_accum_ff << 3) + (length_accum_ff << 1) + dval;
                     digit_count_in  = digit_count_ff + 4'd1;
                  end
               end else begin
                  bytes_required_in = 32'(length_accum_ff) + 32'(digit_count_ff) + 32'd2;
                  if (data_byte != CharColon) begin
                     pending_error_in = StNoColon;
                     phase_in         = PhError;
                  end else begin
                     payload_left_in = length_accum_ff;
                     phase_in        = (length_accum_ff != '0) ? PhPayload : PhComma;
                  end
               end
            end
            PhPayload: begin
               r0_valid       = 1'b1;
               r0.kind        = KindByte;
               r0.out_byte    = data_byte;
               r0.is_value    = value_side_ff;
               r0.entry_index = pair_index_ff;
               payload_left_in = payload_left_ff - 30'd1;
               if (payload_left_in == '0) begin
                  phase_in = PhComma;
               end
            end
            PhComma: begin
               if (data_byte != CharComma) begin
                  pending_error_in = StNoComma;
                  phase_in         = PhError;
               end else begin
                  r0_valid         = 1'b1;
                  r0.kind          = KindEnd;
                  r0.is_value      = value_side_ff;
                  r0.entry_index   = pair_index_ff;
                  r0.string_length = length_accum_ff;
                  bytes_since_in   = '0;
                  digit_count_in   = '0;
                  length_accum_in  = '0;
                  if (value_side_ff) begin
                     value_side_in   = 1'b0;
                     pair_index_in   = pair_index_ff + 32'd1;
                     entries_left_in = entries_left_ff - 32'd1;
                     phase_in        = (entries_left_in == '0) ? PhIdle : PhFirst;
                  end else begin
                     value_side_in = 1'b1;
                     phase_in      = PhFirst;
                  end
               end
            end
            default: begin
            end
         endcase

         r0.last = !frame_end;

         if (frame_end) begin
            if (phase_in == PhHead) begin
               st = StHdrShort;
            end else if (phase_in == PhIdle) begin
               st = StOk;
            end else if (phase_in == PhError) begin
               st = (bytes_since_in < bytes_required_in) ? StTooShort : pending_error_in;
            end else if ((phase_in == PhFirst) && (bytes_since_in == '0)) begin
               st = value_side_in ? StTooShort : StMissing;
            end else begin
               st = StTooShort;
            end
            r1.kind        = KindStatus;
            r1.entry_index = pair_index_in;
            r1.status      = st;
            r1.entry_count = (phase_in == PhHead) ? '0 : count_value_in;
            r1.last        = 1'b1;

            phase_in          = PhHead;
            header_bytes_in   = '0;
            count_value_in    = '0;
            entries_left_in   = '0;
            pair_index_in     = '0;
            digit_count_in    = '0;
            length_accum_in   = '0;
            payload_left_in   = '0;
            value_side_in     = 1'b0;
            pending_error_in  = StOk;
            bytes_required_in = '0;
            bytes_since_in    = '0;
         end
      end

      push.count  = accept ? (2'(r0_valid) + 2'(frame_end)) : 2'd0;
      push.first  = r0_valid ? r0 : r1;
      push.second = r1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= PhHead;
         header_bytes_ff   <= '0;
         count_value_ff    <= '0;
         entries_left_ff   <= '0;
         pair_index_ff     <= '0;
         digit_count_ff    <= '0;
         length_accum_ff   <= '0;
         payload_left_ff   <= '0;
         value_side_ff     <= 1'b0;
         pending_error_ff  <= StOk;
         bytes_required_ff <= '0;
         bytes_since_ff    <= '0;
      end else begin
         phase_ff          <= phase_in;
         header_bytes_ff   <= header_bytes_in;
         count_value_ff    <= count_value_in;
         entries_left_ff   <= entries_left_in;
         pair_index_ff     <= pair_index_in;
         digit_count_ff    <= digit_count_in;
         length_accum_ff   <= length_accum_in;
         payload_left_ff   <= payload_left_in;
         value_side_ff     <= value_side_in;
         pending_error_ff  <= pending_error_in;
         bytes_required_ff <= bytes_required_in;
         bytes_since_ff    <= bytes_since_in;
      end
   end

   `NMD_ASSERT(a_two_results,
      push.count == 2'd2 |->
         (push.first.kind != KindStatus) && (push.second.kind == KindStatus),
      "status must follow a payload result")
   `NMD_ASSERT(a_header_bytes, phase_ff == PhHead |-> header_bytes_ff <= 3'd3, "header byte count out of range")
   `NMD_ASSERT(a_frame_restart,
      accept && frame_end |=> (phase_ff == PhHead) && (pair_index_ff == '0),
      "frame end did not restart parser")

endmodule

// ===== rtl/netstring_metadata_deframer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// netstring_metadata_deframer
// Deframes a metadata frame of netstring key/value pairs, one byte a cycle.
//
//   channel  direction  ports         content
//   req      in         req_*         frame byte and frame end flag
//   rsp      out        rsp_*         payload byte, string end or frame status
//   csr      in         csr_*         swap_count register write
//
// One byte is accepted per cycle while req_ready is high; the parser updates
// its state in the cycle of acceptance and the results land in a four-entry
// result queue, visible on rsp from the next cycle; a byte yields at most two
// results. req_ready drops while the queue holds three or more results; bytes
// that yield no result keep flowing under a stalled rsp side until then.
// Reset clears the parser, the queue and swap_count; no clearing pass.
// ----------------------------------------------------------------------------
module netstring_metadata_deframer
   import nmd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_frame_end,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_is_value,
   output logic [31:0] rsp_entry_index,
   output logic [29:0] rsp_string_length,
   output logic [3:0]  rsp_status,
   output logic [31:0] rsp_entry_count,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_swap_count
);

   logic           swap_count_ff, swap_count_in;
   logic           accept;
   logic           space_ok;
   nmd_push_type   push;
   nmd_result_type rsp_data;

   assign csr_ready = 1'b1;
   assign req_ready = space_ok;
   assign accept    = req_valid && space_ok;

   always_comb begin
      swap_count_in = swap_count_ff;
      if (csr_valid) begin
         swap_count_in = csr_swap_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         swap_count_ff <= 1'b0;
      end else begin
         swap_count_ff <= swap_count_in;
      end
   end

   nmd_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .data_byte  (req_data_byte),
      .frame_end  (req_frame_end),
      .swap_count (swap_count_ff),
      .push       (push)
   );

   nmd_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .space_ok  (space_ok),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_kind          = rsp_data.kind;
   assign rsp_out_byte      = rsp_data.out_byte;
   assign rsp_is_value      = rsp_data.is_value;
   assign rsp_entry_index   = rsp_data.entry_index;
   assign rsp_string_length = rsp_data.string_length;
   assign rsp_status        = rsp_data.status;
   assign rsp_entry_count   = rsp_data.entry_count;
   assign rsp_last          = rsp_data.last;

endmodule
